// ----- src/upq_pkg.sv -----
// Shared types and constants for the urgency priority queue.
// No dependencies; imported by upq_ram users, upq_ctrl and the top level.
package upq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int REC_W        = 47;
  localparam int TICKET_W     = 5;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Patient record, age in the lowest bits.
  typedef struct packed {
    logic [31:0] tag;
    logic [2:0]  urgency;
    logic [1:0]  insurance;
    logic [1:0]  sex;
    logic [7:0]  age;
  } rec_t;

  // One result word handed from the controller to the output register.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket;
    rec_t                rec;
  } res_t;

endpackage

// ----- src/urgency_priority_queue.sv -----
// Top level of the urgency priority queue: stream ports, output register,
// controller and record RAM. Depends on upq_pkg, upq_ctrl and upq_ram.
//
// Usage. Each input word carries one operation in s_tuser (0 enqueue,
// 1 sort by urgency, 2 dequeue) and a patient record in s_tdata. Every
// accepted word produces exactly one output word: status in m_tuser and the
// ticket plus, for a dequeue, the patient record in m_tdata.
// Enqueue stores the record at the rear slot and returns ticket = slot + 1,
// or status full once the rear reaches CAPACITY; slots are never reused, so
// the queue stays full after removals. Dequeue returns the front record, or
// status empty with all-zero data. Sort reorders the live slots with a plain
// exchange sort (not stable), highest urgency first.
// Timing. Enqueue, rejected operations and trivial sorts give their result
// word in the cycle after acceptance; a dequeue first passes through the DEQ
// and FIN states because the record RAM has a registered read. A sort walks
// every pair with one comparator on the single RAM read port (states RDJ and
// CMP), plus a load (RDI, LDI) and a write-back (WBI) per front slot.
// The block takes one word at a time and is ready again once its result
// sits in the output register.
// Reset clears the front and rear indexes, so the queue starts empty; the
// RAM contents are not cleared. When the receiver stalls, the result holds in
// the output register and s_tready stays low until it is taken.
module urgency_priority_queue import upq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: age[7:0], sex[1:0], insurance[1:0], urgency[2:0],
  // tag[31:0], then one zero pad bit.
  input  logic [47:0] s_tdata,
  // s_tuser: mode[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: ticket[4:0], out_age[7:0], out_sex[1:0],
  // out_insurance[1:0], out_urgency[2:0], out_tag[31:0], then four zero bits.
  output logic [55:0] m_tdata,
  // m_tuser: status[1:0].
  output logic [1:0]  m_tuser
);

  localparam int AW = $clog2(CAPACITY);

  res_t             res;
  logic             res_ready;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  // The output register is free when empty or being taken this cycle.
  assign res_ready = !m_tvalid || m_tready;

  upq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_rec    (rec_t'(s_tdata[REC_W-1:0])),
    .res       (res),
    .res_ready (res_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  upq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_records (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: control bit reset, payload loaded with each new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      m_tdata <= {4'b0000, res.rec, res.ticket};
      m_tuser <= res.status;
    end
  end

endmodule

// ----- src/upq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module upq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/upq_ctrl.sv -----
// Sequencer of the urgency priority queue: front and rear indexes, the
// exchange-sort walk with its single urgency comparator. Depends on upq_pkg.
module upq_ctrl import upq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [MODE_W-1:0]           in_mode,
  input  rec_t                        in_rec,
  output res_t                        res,
  input  logic                        res_ready,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [REC_W-1:0]            ram_wdata,
  output logic                        ram_re,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [REC_W-1:0]            ram_rdata
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (IW + 1 > TICKET_W) ? IW + 1 : TICKET_W;
  localparam logic [IW:0] CAP_X = (IW + 1)'(CAPACITY);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DEQ  = 8'b0000_0010,
    ST_RDI  = 8'b0000_0100,
    ST_LDI  = 8'b0000_1000,
    ST_RDJ  = 8'b0001_0000,
    ST_CMP  = 8'b0010_0000,
    ST_WBI  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [IW-1:0]       i;
  logic [IW-1:0]       j;
  rec_t                cur;
  logic [STATUS_W-1:0] pend_status;
  logic [TICKET_W-1:0] pend_ticket;
  logic                pend_has_rec;

  logic accept;
  logic full;
  logic empty;
  logic sort_needed;
  logic j_last;
  logic i_last;
  logic swap;
  rec_t rd_rec;

  // Ticket of a slot is its index plus one, kept to the ticket width.
  function automatic logic [TICKET_W-1:0] ticket_of(input logic [IW-1:0] idx);
    logic [XW-1:0] t;
    t = XW'(idx) + XW'(1);
    return t[TICKET_W-1:0];
  endfunction

  assign rd_rec      = rec_t'(ram_rdata);
  assign full        = {1'b0, tail} >= CAP_X;
  assign empty       = head >= tail;
  assign sort_needed = ({1'b0, head} + (IW + 1)'(1)) < {1'b0, tail};
  assign j_last      = ({1'b0, j} + (IW + 1)'(1)) >= {1'b0, tail};
  assign i_last      = ({1'b0, i} + (IW + 1)'(2)) >= {1'b0, tail};
  assign swap        = cur.urgency < rd_rec.urgency;

  assign in_ready = (state == ST_IDLE) && res_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail[AW-1:0];
    ram_wdata = in_rec;
    ram_re    = 1'b0;
    ram_raddr = head[AW-1:0];
    res       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_ENQ: begin
              res.valid = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                res.ticket = ticket_of(tail);
              end
            end
            MODE_SORT: begin
              res.valid = !sort_needed;
            end
            MODE_DEQ: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      ST_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = i[AW-1:0];
      end
      ST_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = j[AW-1:0];
      end
      ST_CMP: begin
        // The running holder of slot i moves down into slot j on a swap.
        ram_we    = swap;
        ram_waddr = j[AW-1:0];
        ram_wdata = cur;
      end
      ST_WBI: begin
        ram_we    = 1'b1;
        ram_waddr = i[AW-1:0];
        ram_wdata = cur;
      end
      ST_FIN: begin
        res.valid  = 1'b1;
        res.status = pend_status;
        res.ticket = pend_ticket;
        res.rec    = pend_has_rec ? cur : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_ENQ: begin
                if (!full) begin
                  tail <= tail + IW'(1);
                end
              end
              MODE_SORT: begin
                if (sort_needed) begin
                  i     <= head;
                  state <= ST_RDI;
                end
              end
              MODE_DEQ: begin
                if (!empty) begin
                  head        <= head + IW'(1);
                  pend_ticket <= ticket_of(head);
                  state       <= ST_DEQ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DEQ: begin
          cur          <= rd_rec;
          pend_status  <= STAT_DONE;
          pend_has_rec <= 1'b1;
          state        <= ST_FIN;
        end
        ST_RDI: begin
          state <= ST_LDI;
        end
        ST_LDI: begin
          cur   <= rd_rec;
          j     <= i + IW'(1);
          state <= ST_RDJ;
        end
        ST_RDJ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (swap) begin
            cur <= rd_rec;
          end
          if (j_last) begin
            state <= ST_WBI;
          end else begin
            j     <= j + IW'(1);
            state <= ST_RDJ;
          end
        end
        ST_WBI: begin
          if (i_last) begin
            pend_status  <= STAT_DONE;
            pend_ticket  <= '0;
            pend_has_rec <= 1'b0;
            state        <= ST_FIN;
          end else begin
            i     <= i + IW'(1);
            state <= ST_RDI;
          end
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("front index passed rear index");

  a_tail_cap: assert property (@(posedge clk) disable iff (rst) {1'b0, tail} <= CAP_X)
    else $error("rear index beyond capacity");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (i < j) && (j < tail) && (head <= i))
    else $error("sort scan indexes out of order");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && !res_ready |=> (state == ST_FIN))
    else $error("pending result dropped");

  a_idle_no_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we && (state == ST_IDLE) |-> accept && (in_mode == MODE_ENQ) && !full)
    else $error("unexpected record write");

endmodule

// ----- sim/urgency_priority_queue_tb.sv -----
// Self-checking testbench for urgency_priority_queue: stream stimulus, random idling on both
// sides and a scoreboard that predicts every result word from its own copy of the slot array.
// Depends on upq_pkg and the RTL of urgency_priority_queue; nothing else.
`timescale 1ns / 100ps

module urgency_priority_queue_tb import upq_pkg::*;;

  // The package names three operations; the fourth code is a no-op.
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int unsigned ITEM_COUNT = 1000;
  localparam int unsigned MAX_PRINTED = 100;

  // One expected result word: status, ticket and the dequeued record.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket;
    rec_t                rec;
  } queue_result_t;

  // The scoreboard keeps its own slot array with front and rear indexes, and
  // a queue of the result words that the block still owes.
  class triage_scoreboard;
    rec_t          slot_rec [CAPACITY_DEF];
    int unsigned   head_slot;
    int unsigned   tail_slot;
    queue_result_t pending_results [$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      head_slot = 0;
      tail_slot = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    // Exchange sort over the live slots, highest urgency first. It swaps
    // whenever a later slot is strictly more urgent, so equal urgencies can
    // change their order.
    function void sort_by_urgency();
      rec_t held;
      if (head_slot >= tail_slot) return;
      for (int unsigned i = head_slot; i + 1 < tail_slot; i++) begin
        for (int unsigned j = i + 1; j < tail_slot; j++) begin
          if (slot_rec[i].urgency < slot_rec[j].urgency) begin
            held = slot_rec[i];
            slot_rec[i] = slot_rec[j];
            slot_rec[j] = held;
          end
        end
      end
    endfunction

    // Called for every input word the block accepted.
    function void note_word(logic [MODE_W-1:0] mode, rec_t rec);
      queue_result_t want;
      want = '0;
      case (mode)
        MODE_ENQ: begin
          // Slots are never reused: once the rear reaches the end the queue
          // stays full, whatever has been dequeued.
          if (tail_slot >= CAPACITY_DEF) begin
            want.status = STAT_FULL;
          end else begin
            slot_rec[tail_slot] = rec;
            tail_slot++;
            want.status = STAT_DONE;
            want.ticket = TICKET_W'(tail_slot);
          end
        end
        MODE_SORT: begin
          sort_by_urgency();
          want.status = STAT_DONE;
        end
        MODE_DEQ: begin
          if (head_slot >= tail_slot) begin
            want.status = STAT_EMPTY;
          end else begin
            want.rec = slot_rec[head_slot];
            head_slot++;
            want.status = STAT_DONE;
            want.ticket = TICKET_W'(head_slot);
          end
        end
        default: want.status = STAT_DONE;
      endcase
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("word %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    // Called for every result word taken from the block.
    task check_word(logic [55:0] tdata, logic [1:0] tuser);
      queue_result_t want;
      rec_t          got;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending, data", tdata, 0);
        return;
      end
      want = pending_results.pop_front();
      got = tdata[51:5];
      if (tuser !== want.status) report_mismatch("status", tuser, want.status);
      if (tdata[4:0] !== want.ticket) report_mismatch("ticket", tdata[4:0], want.ticket);
      if (got.age !== want.rec.age) report_mismatch("age", got.age, want.rec.age);
      if (got.sex !== want.rec.sex) report_mismatch("sex", got.sex, want.rec.sex);
      if (got.insurance !== want.rec.insurance)
        report_mismatch("insurance", got.insurance, want.rec.insurance);
      if (got.urgency !== want.rec.urgency)
        report_mismatch("urgency", got.urgency, want.rec.urgency);
      if (got.tag !== want.rec.tag) report_mismatch("tag", got.tag, want.rec.tag);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // age, sex, insurance, urgency, tag, one pad bit
  logic [1:0]  s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // ticket, age, sex, insurance, urgency, tag, four pad bits
  logic [1:0]  m_tuser;   // status

  triage_scoreboard sb = new();
  bit sender_idles = 1'b1;

  urgency_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Hard limit: the slowest correct run, with a full sort on every sort word,
  // stays far below this.
  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly in-range urgencies so that ties are common, with the odd 0, 6 or 7.
  function automatic rec_t random_record();
    rec_t r;
    r.age = 8'($urandom_range(0, 255));
    r.sex = 2'($urandom_range(0, 3));
    r.insurance = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) r.urgency = 3'($urandom_range(0, 7));
    else r.urgency = 3'($urandom_range(1, 5));
    r.tag = $urandom;
    return r;
  endfunction

  // Offers one word from the falling edge on and returns at the falling edge
  // after it was taken. Idle cycles come first, so tvalid only drops between
  // words and never gets two assignments in one step.
  task automatic send_word(logic [MODE_W-1:0] mode, rec_t rec);
    while (sender_idles && $urandom_range(0, 99) < 37) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, rec};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(mode, rec);
    @(negedge clk);
  endtask

  // Receiver: random stalls, a long stretch with none, and once a long hold
  // while the sender keeps offering, so that the output register fills and
  // the block drops s_tready.
  initial begin
    int unsigned words_taken;
    int unsigned hold_left;
    bit          held;
    words_taken = 0;
    hold_left = 0;
    held = 1'b0;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held && words_taken == 150) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (words_taken >= 400 && words_taken < 600) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 37);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        words_taken++;
        sb.check_word(m_tdata, m_tuser);
      end
    end
  end

  initial begin
    int unsigned   enqueues;
    int unsigned   pick;
    logic [MODE_W-1:0] mode;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_ENQ;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: operations on an empty queue, the no-op code, the field
    // extremes, a sort that must swap, and dequeues down to empty again with
    // the front index no longer at zero.
    send_word(MODE_DEQ, random_record());
    send_word(MODE_SORT, random_record());
    send_word(MODE_NOP, random_record());
    send_word(MODE_ENQ, '{tag: 32'h0, urgency: 3'd1, insurance: 2'd1, sex: 2'd1, age: 8'd0});
    send_word(MODE_ENQ,
              '{tag: 32'hFFFF_FFFF, urgency: 3'd5, insurance: 2'd2, sex: 2'd2, age: 8'd255});
    send_word(MODE_SORT, random_record());
    send_word(MODE_DEQ, random_record());
    send_word(MODE_DEQ, random_record());
    send_word(MODE_DEQ, random_record());
    send_word(MODE_SORT, random_record());
    send_word(MODE_NOP, random_record());
    enqueues = 2;

    // Random part. While slots remain, sorts come often so that they meet
    // many fill levels and front positions; once the rear has reached the
    // end, full enqueues, sorts of what is left and dequeues to empty follow.
    for (int n = 0; n < ITEM_COUNT; n++) begin
      sender_idles = !(n >= 400 && n < 600);
      pick = $urandom_range(0, 99);
      if (enqueues < CAPACITY_DEF) begin
        if (pick < 50) mode = MODE_ENQ;
        else if (pick < 75) mode = MODE_SORT;
        else if (pick < 90) mode = MODE_DEQ;
        else mode = MODE_NOP;
      end else begin
        if (pick < 30) mode = MODE_ENQ;
        else if (pick < 60) mode = MODE_SORT;
        else if (pick < 90) mode = MODE_DEQ;
        else mode = MODE_NOP;
      end
      send_word(mode, random_record());
      if (mode == MODE_ENQ) enqueues++;
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a full sort's worth of cycles for any stray word.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
